FILE: src/msie_pkg.sv
// Shared types, instruction codes and reset contents for the MIPS subset executor.
package msie_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned RIDX_W = 5;
    localparam int unsigned CTL_W  = 9;
    localparam int unsigned STAT_W = 2;

    // Major opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-type function codes
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    // Main control words: RegDst,ALUOp1,ALUOp0,ALUSrc,Branch,MemRead,MemWrite,RegWrite,MemtoReg
    localparam logic [CTL_W-1:0] CTL_NONE  = 9'h000;
    localparam logic [CTL_W-1:0] CTL_RTYPE = 9'h182;
    localparam logic [CTL_W-1:0] CTL_IMM   = 9'h022;
    localparam logic [CTL_W-1:0] CTL_LW    = 9'h02B;
    localparam logic [CTL_W-1:0] CTL_SW    = 9'h024;
    localparam logic [CTL_W-1:0] CTL_BNE   = 9'h050;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CODE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

    function automatic logic [WORD_W-1:0] reg_init(input logic [RIDX_W-1:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            5'd1:    v = 32'd9;
            5'd2:    v = 32'd8;
            5'd3:    v = 32'd7;
            5'd4:    v = 32'd1;
            5'd5:    v = 32'd2;
            5'd6:    v = 32'd3;
            5'd7:    v = 32'd4;
            5'd8:    v = 32'd5;
            5'd9:    v = 32'd6;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] mem_init(input logic [9:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            10'd0:   v = 32'd5;
            10'd1:   v = 32'd9;
            10'd2:   v = 32'd4;
            10'd3:   v = 32'd8;
            10'd4:   v = 32'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/msie_regfile.sv
// Register file: two synchronous read ports, one write port, bypass and preset sweep.
module msie_regfile
    import msie_pkg::*;
#(
    parameter int NUM_REGS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [RIDX_W-1:0] rs_a,
    input  logic [RIDX_W-1:0] rs_b,
    input  rf_wr_t            wr,
    output logic [WORD_W-1:0] a,
    output logic [WORD_W-1:0] b,
    output logic              init_done
);

    localparam int RW = $clog2(NUM_REGS);
    localparam logic [RIDX_W:0] NREG = (RIDX_W+1)'(NUM_REGS);

    logic [WORD_W-1:0] rf_mem [NUM_REGS];

    logic [RW-1:0]     cnt_reg;
    logic [RW-1:0]     cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic [WORD_W-1:0] q_a_reg;
    logic [WORD_W-1:0] q_b_reg;
    logic              a_zero_reg;
    logic              b_zero_reg;
    logic              a_byp_reg;
    logic              b_byp_reg;
    logic [WORD_W-1:0] byp_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == RW'(NUM_REGS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Preset sweep owns the write port until it finishes
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rf_mem[cnt_reg] <= reg_init(RIDX_W'(cnt_reg));
        end
        else if (wr.en)
        begin
            rf_mem[wr.idx[RW-1:0]] <= wr.data;
        end
    end

    // Read, with a bypass of the write landing on the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_a_reg    <= rf_mem[rs_a[RW-1:0]];
            q_b_reg    <= rf_mem[rs_b[RW-1:0]];
            a_zero_reg <= (rs_a == '0) || ({1'b0, rs_a} >= NREG);
            b_zero_reg <= (rs_b == '0) || ({1'b0, rs_b} >= NREG);
            a_byp_reg  <= wr.en && (wr.idx == rs_a);
            b_byp_reg  <= wr.en && (wr.idx == rs_b);
            byp_reg    <= wr.data;
        end
    end

    assign a = a_zero_reg ? '0 : (a_byp_reg ? byp_reg : q_a_reg);
    assign b = b_zero_reg ? '0 : (b_byp_reg ? byp_reg : q_b_reg);
    assign init_done = !busy_reg;

endmodule

FILE: src/msie_dmem.sv
// Word data memory: one synchronous read/write port and preset sweep.
module msie_dmem
    import msie_pkg::*;
#(
    parameter int MEM_WORDS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic                         wr_en,
    input  logic [$clog2(MEM_WORDS)-1:0] idx,
    input  logic [WORD_W-1:0]            wdata,
    output logic [WORD_W-1:0]            q,
    output logic                         init_done
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [WORD_W-1:0] dmem [MEM_WORDS];

    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic [WORD_W-1:0] q_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == AW'(MEM_WORDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            dmem[cnt_reg] <= mem_init(10'(cnt_reg));
        end
        else if (wr_en)
        begin
            dmem[idx] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg <= dmem[idx];
        end
    end

    assign q = q_reg;
    assign init_done = !busy_reg;

endmodule

FILE: src/mips_subset_instruction_executor.sv
// Top level of the MIPS subset executor: decode, ALU, pipeline control and output word.
//
// Executes one MIPS instruction word per input word, in order: add, sub, and,
// or, slt, addi, andi, lw, sw and bne, against a 32-bit register file and a
// word-addressed data memory of MEM_WORDS words. Throughput is one instruction
// per cycle while the output takes each result word. Stage 1 holds the
// instruction and its register file read; stage 2, the output register, holds
// its ALU result and data memory read. The register file is written when the
// result word leaves, and a following instruction that needs that value
// takes it straight from the output register, so back-to-back dependent
// instructions, including a load followed by its use, run without a bubble.
// The two stages hold each other only through the output handshake: while a
// result waits, one further instruction is still taken. After reset the
// block loads its preset contents (registers 1..9 = 9,8,7,1,2,3,4,5,6,
// memory words 0..4 = 5,9,4,8,7, the rest zero), one entry per cycle; it
// takes no instruction until both preset sweeps have finished. Unknown opcodes
// or function codes give status 1 and change nothing; a load or store whose
// byte address is unaligned or beyond the memory gives status 2 and changes
// nothing. Register zero and registers at or above NUM_REGS read as zero and
// ignore writes. Branches are evaluated only, nothing is redirected.
module mips_subset_instruction_executor
    import msie_pkg::*;
#(
    parameter int NUM_REGS  = 32,
    parameter int MEM_WORDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [8:0] control_bits, [40:9] alu_result, [72:41] load_data, [77:73] dest_reg,
    // [78] reg_written, [79] not_equal, [81:80] status, [87:82] zero
    output logic [87:0] m_axis_tdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [RIDX_W:0] NREG = (RIDX_W+1)'(NUM_REGS);

    // Stage 1: instruction waiting for its operands from the register file
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [31:0]       s1_instr_reg;

    // Stage 2: output register
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [CTL_W-1:0]  s2_ctl_reg;
    logic [WORD_W-1:0] s2_alu_reg;
    logic [RIDX_W-1:0] s2_dst_reg;
    logic              s2_wr_reg;
    logic              s2_ne_reg;
    logic [STAT_W-1:0] s2_st_reg;
    logic              s2_ld_reg;

    logic              in_fire;
    logic              s1_go;
    logic              out_fire;
    logic              rf_ready;
    logic              dm_ready;

    logic [WORD_W-1:0] rf_a;
    logic [WORD_W-1:0] rf_b;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
    logic [WORD_W-1:0] s2_wval;
    logic [WORD_W-1:0] dm_q;
    logic [WORD_W-1:0] load_data;
    rf_wr_t            rf_wr;

    logic [5:0]        opc;
    logic [5:0]        fn;
    logic [RIDX_W-1:0] rs;
    logic [RIDX_W-1:0] rt;
    logic [RIDX_W-1:0] rd;
    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] zimm;
    logic [WORD_W-1:0] addr;
    logic              addr_ok;

    logic [CTL_W-1:0]  ctl;
    logic [WORD_W-1:0] alu;
    logic [RIDX_W-1:0] dst;
    logic              wr;
    logic              ne;
    logic [STAT_W-1:0] st;
    logic              is_ld;
    logic              is_st;

    // Handshakes: stage 1 moves when the output register is empty or drained
    assign s1_go         = s1_valid_reg && (!s2_valid_reg || m_axis_tready);
    assign s_axis_tready = rf_ready && dm_ready && (!s1_valid_reg || s1_go);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = s2_valid_reg;
    assign out_fire      = s2_valid_reg && m_axis_tready;

    // Writeback happens as the result word leaves
    assign s2_wval    = s2_ld_reg ? dm_q : s2_alu_reg;
    assign rf_wr.en   = out_fire && s2_wr_reg;
    assign rf_wr.idx  = s2_dst_reg;
    assign rf_wr.data = s2_wval;

    msie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rs_a      (s_axis_tdata[25:21]),
        .rs_b      (s_axis_tdata[20:16]),
        .wr        (rf_wr),
        .a         (rf_a),
        .b         (rf_b),
        .init_done (rf_ready)
    );

    // Field split of the instruction in stage 1
    assign opc  = s1_instr_reg[31:26];
    assign rs   = s1_instr_reg[25:21];
    assign rt   = s1_instr_reg[20:16];
    assign rd   = s1_instr_reg[15:11];
    assign fn   = s1_instr_reg[5:0];
    assign simm = {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};
    assign zimm = {16'h0000, s1_instr_reg[15:0]};

    // Forward the pending writeback of the older instruction in the output register
    assign op_a = (s2_valid_reg && s2_wr_reg && (s2_dst_reg == rs)) ? s2_wval : rf_a;
    assign op_b = (s2_valid_reg && s2_wr_reg && (s2_dst_reg == rt)) ? s2_wval : rf_b;

    assign addr    = op_a + simm;
    assign addr_ok = (addr[1:0] == 2'b00) && (addr[31:2] < 30'(MEM_WORDS));

    function automatic logic reg_ok(input logic [RIDX_W-1:0] idx);
        return (idx != '0) && ({1'b0, idx} < NREG);
    endfunction

    always_comb
    begin
        ctl   = CTL_NONE;
        alu   = '0;
        dst   = '0;
        wr    = 1'b0;
        ne    = 1'b0;
        st    = ST_OK;
        is_ld = 1'b0;
        is_st = 1'b0;
        unique case (opc)
            OP_RTYPE:
            begin
                ctl = CTL_RTYPE;
                dst = rd;
                wr  = reg_ok(rd);
                unique case (fn)
                    FN_ADD: alu = op_a + op_b;
                    FN_SUB: alu = op_a - op_b;
                    FN_AND: alu = op_a & op_b;
                    FN_OR:  alu = op_a | op_b;
                    FN_SLT: alu = {31'd0, $signed(op_a) < $signed(op_b)};
                    default:
                    begin
                        // unknown function: report and drop
                        ctl = CTL_NONE;
                        dst = '0;
                        wr  = 1'b0;
                        st  = ST_BAD_CODE;
                    end
                endcase
            end
            OP_ADDI:
            begin
                ctl = CTL_IMM;
                alu = addr;
                dst = rt;
                wr  = reg_ok(rt);
            end
            OP_ANDI:
            begin
                ctl = CTL_IMM;
                alu = op_a & zimm;
                dst = rt;
                wr  = reg_ok(rt);
            end
            OP_LW:
            begin
                ctl   = CTL_LW;
                alu   = addr;
                dst   = rt;
                is_ld = addr_ok;
                wr    = addr_ok && reg_ok(rt);
                st    = addr_ok ? ST_OK : ST_BAD_ADDR;
            end
            OP_SW:
            begin
                ctl   = CTL_SW;
                alu   = addr;
                dst   = rt;
                is_st = addr_ok;
                st    = addr_ok ? ST_OK : ST_BAD_ADDR;
            end
            OP_BNE:
            begin
                ctl = CTL_BNE;
                alu = op_a - op_b;
                dst = rt;
                ne  = (op_a != op_b);
            end
            default:
            begin
                st = ST_BAD_CODE;
            end
        endcase
    end

    // Data memory is read or written as the instruction leaves stage 1
    msie_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s1_go && is_ld),
        .wr_en     (s1_go && is_st),
        .idx       (addr[AW+1:2]),
        .wdata     (op_b),
        .q         (dm_q),
        .init_done (dm_ready)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_go)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= s_axis_tdata;
        end
        if (s1_go)
        begin
            s2_ctl_reg <= ctl;
            s2_alu_reg <= alu;
            s2_dst_reg <= dst;
            s2_wr_reg  <= wr;
            s2_ne_reg  <= ne;
            s2_st_reg  <= st;
            s2_ld_reg  <= is_ld;
        end
    end

    // Load data shows only for a load that went to memory
    assign load_data = s2_ld_reg ? dm_q : '0;

    assign m_axis_tdata = {6'd0, s2_st_reg, s2_ne_reg, s2_wr_reg, s2_dst_reg,
                           load_data, s2_alu_reg, s2_ctl_reg};

endmodule
